>>> rtl/maximal_square_finder_defines.svh
// Assertion macros used by the maximal square finder RTL
`ifndef MAXIMAL_SQUARE_FINDER_DEFINES_SVH
`define MAXIMAL_SQUARE_FINDER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define MSF_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("maximal_square_finder: check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define MSF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("maximal_square_finder: check failed");

`endif

>>> rtl/msf_pkg.sv
// Types and constants of the maximal square finder
package msf_pkg;

	localparam int SIZE_W = 11;
	localparam int POS_W  = 10;

	localparam logic [SIZE_W-1:0] SIZE_SAT = 11'h7FF;

	localparam logic [7:0]        EMPTY_CHAR_RST = 8'd46;
	localparam logic [SIZE_W-1:0] ROW_WIDTH_RST  = 11'd1024;

	// register index, taken from paddr[2]
	localparam logic REG_EMPTY_CHAR = 1'b0;
	localparam logic REG_ROW_WIDTH  = 1'b1;

	typedef struct packed {
		logic free;   // character matched empty_char
		logic first;  // first row or first column
		logic last;   // final cell of the map
	} cell_ctl_t;

	typedef struct packed {
		logic [POS_W-1:0]  col;
		logic [POS_W-1:0]  row;
		logic [SIZE_W-1:0] size;
	} best_t;

endpackage

>>> rtl/msf_best_track.sv
// Square size recurrence with left/up-left registers and best-square tracking
module msf_best_track (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  msf_pkg::cell_ctl_t           ctl,
	input  logic [msf_pkg::SIZE_W-1:0]   up,
	input  logic [msf_pkg::POS_W-1:0]    row,
	input  logic [msf_pkg::POS_W-1:0]    col,
	output logic [msf_pkg::SIZE_W-1:0]   size,
	output msf_pkg::best_t               best
);

	logic [msf_pkg::SIZE_W-1:0] left_q;
	logic [msf_pkg::SIZE_W-1:0] upleft_q;
	msf_pkg::best_t             best_q;
	logic [msf_pkg::SIZE_W-1:0] min_v;
	logic [msf_pkg::SIZE_W:0]   sum_v;

	always_comb begin
		min_v = left_q;
		if (up < min_v) min_v = up;
		if (upleft_q < min_v) min_v = upleft_q;
		sum_v = {1'b0, min_v} + {{msf_pkg::SIZE_W{1'b0}}, 1'b1};
		if (!ctl.free) begin
			size = '0;
		end else if (ctl.first) begin
			size = msf_pkg::SIZE_W'(1);
		end else if (sum_v[msf_pkg::SIZE_W]) begin
			size = msf_pkg::SIZE_SAT;
		end else begin
			size = sum_v[msf_pkg::SIZE_W-1:0];
		end
		// strict compare keeps the first square in raster order on ties
		if (size > best_q.size) begin
			best.size = size;
			best.row  = row;
			best.col  = col;
		end else begin
			best = best_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			upleft_q <= '0;
			best_q   <= '0;
		end else if (adv) begin
			if (ctl.last) begin
				left_q   <= '0;
				upleft_q <= '0;
				best_q   <= '0;
			end else begin
				left_q   <= size;
				upleft_q <= up;
				best_q   <= best;
			end
		end
	end

endmodule

>>> rtl/maximal_square_finder.sv
// A word accepted on the slave side passes the stage-one and the output register to the master side.
// Throughput: one word per cycle while m_axis_tready does not stall; the previous-row store is read
// and written once each per cycle. Left-neighbour min-plus-one loop closes through left_q alone;
// same-column words back to back (width-one rows, first word after a map) use read forwarding.
// Reset: arst_n clears counters, best square, pipeline valids and restores empty_char = 46,
// row_width = 1024; the previous-row store is not cleared, the first row ignores what it reads.
module maximal_square_finder #(
	parameter int MAX_COLS = 1024,
	parameter int MAX_ROWS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] cell_char
	input  logic        s_axis_tlast,   // last_cell
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // [10:0] cell_size, [21:11] best_size,
	                                    // [31:22] best_row, [41:32] best_col, [47:42] zero
	output logic        m_axis_tlast    // map_done
);

`include "maximal_square_finder_defines.svh"

	localparam int CW = $clog2(MAX_COLS);
	localparam int RW = $clog2(MAX_ROWS);
	localparam int EW = (CW + 1 > msf_pkg::SIZE_W) ? CW + 1 : msf_pkg::SIZE_W;

	logic [7:0]                 empty_char_q;
	logic [msf_pkg::SIZE_W-1:0] row_width_q;
	logic                       cfg_wr;

	logic [EW-1:0] rw_ext;
	logic [EW-1:0] width_eff;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          wrap0;
	logic          wrap1;
	logic [CW-1:0] c0;
	logic [RW-1:0] r0;
	logic [CW:0]   c_next;
	logic [CW-1:0] col_d;
	logic [RW-1:0] row_d;
	logic          acc;

	logic                       s1_valid_q;
	logic [CW-1:0]              c_s1;
	logic [RW-1:0]              r_s1;
	msf_pkg::cell_ctl_t         ctl_s1;
	logic [msf_pkg::SIZE_W-1:0] rd_s1;
	logic                       fwd_s1;
	logic [msf_pkg::SIZE_W-1:0] fwd_val_s1;
	logic [msf_pkg::SIZE_W-1:0] up_s1;
	logic                       s1_adv;
	logic                       out_adv;

	logic [msf_pkg::SIZE_W-1:0] mem [MAX_COLS];

	logic [msf_pkg::SIZE_W-1:0] size;
	msf_pkg::best_t             best;

	logic                       out_valid_q;
	logic [msf_pkg::SIZE_W-1:0] out_size_q;
	msf_pkg::best_t             out_best_q;
	logic                       out_last_q;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_char_q <= msf_pkg::EMPTY_CHAR_RST;
			row_width_q  <= msf_pkg::ROW_WIDTH_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				msf_pkg::REG_EMPTY_CHAR: empty_char_q <= pwdata[7:0];
				msf_pkg::REG_ROW_WIDTH:  row_width_q  <= pwdata[msf_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			msf_pkg::REG_EMPTY_CHAR: prdata = {24'd0, empty_char_q};
			msf_pkg::REG_ROW_WIDTH:  prdata = 32'(row_width_q);
			default:                 prdata = '0;
		endcase
	end

	// width of zero acts as one, above the store depth acts as the depth
	always_comb begin
		rw_ext = EW'(row_width_q);
		if (rw_ext == '0) begin
			width_eff = EW'(1);
		end else if (rw_ext > EW'(MAX_COLS)) begin
			width_eff = EW'(MAX_COLS);
		end else begin
			width_eff = rw_ext;
		end
	end

	// handshake
	assign out_adv       = !out_valid_q || m_axis_tready;
	assign s1_adv        = s1_valid_q && out_adv;
	assign s_axis_tready = !s1_valid_q || out_adv;
	assign acc           = s_axis_tvalid && s_axis_tready;

	// column/row position; a shrunk width ends the row before the word
	always_comb begin
		wrap0 = EW'(col_q) >= width_eff;
		c0    = wrap0 ? '0 : col_q;
		r0    = row_q;
		if (wrap0 && (row_q < RW'(MAX_ROWS - 1))) r0 = row_q + RW'(1);
		c_next = {1'b0, c0} + (CW+1)'(1);
		wrap1  = EW'(c_next) >= width_eff;
		col_d  = wrap1 ? '0 : c_next[CW-1:0];
		row_d  = r0;
		if (wrap1 && (r0 < RW'(MAX_ROWS - 1))) row_d = r0 + RW'(1);
		if (s_axis_tlast) begin
			col_d = '0;
			row_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				col_q <= col_d;
				row_q <= row_d;
			end
			if (s_axis_tready) s1_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			c_s1         <= c0;
			r_s1         <= r0;
			ctl_s1.free  <= (s_axis_tdata == empty_char_q);
			ctl_s1.first <= (r0 == '0) || (c0 == '0);
			ctl_s1.last  <= s_axis_tlast;
			// write of the previous word to the same entry lands this edge
			fwd_s1       <= s1_adv && (c_s1 == c0);
			fwd_val_s1   <= size;
		end
	end

	// previous-row store, read-before-write
	always_ff @(posedge clk) begin
		if (s1_adv) mem[c_s1] <= size;
		if (acc) rd_s1 <= mem[c0];
	end

	assign up_s1 = fwd_s1 ? fwd_val_s1 : rd_s1;

	msf_best_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (s1_adv),
		.ctl    (ctl_s1),
		.up     (up_s1),
		.row    (msf_pkg::POS_W'(r_s1)),
		.col    (msf_pkg::POS_W'(c_s1)),
		.size   (size),
		.best   (best)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_size_q <= size;
			out_best_q <= best;
			out_last_q <= ctl_s1.last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_best_q.col, out_best_q.row, out_best_q.size, out_size_q};
	assign m_axis_tlast  = out_last_q;

	`MSF_ASSERT_NOW(a_best_covers_cell, m_axis_tvalid,
		m_axis_tdata[21:11] >= m_axis_tdata[10:0])
	`MSF_ASSERT_NOW(a_no_best_at_origin, m_axis_tvalid && (m_axis_tdata[21:11] == '0),
		(m_axis_tdata[31:22] == '0) && (m_axis_tdata[41:32] == '0))
	`MSF_ASSERT_NEXT(a_last_clears_pos, acc && s_axis_tlast,
		(col_q == '0) && (row_q == '0))
	`MSF_ASSERT_NOW(a_fwd_only_col0, s1_valid_q && fwd_s1, c_s1 == '0)

endmodule
